>>> rtl/core/tsms_pkg.sv
package tsms_pkg;

	localparam int COORD_W   = 21;
	localparam int FRAC_BITS = 10;
	localparam int LEN_W     = 20;
	localparam int EPS_W     = 30;
	localparam int VEC_W     = 3 * COORD_W;
	localparam int OP_W      = 2;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1074);

	localparam logic [OP_W-1:0] OP_NORMAL = 2'd0;
	localparam logic [OP_W-1:0] OP_ENDS   = 2'd1;
	localparam logic [OP_W-1:0] OP_UV     = 2'd2;
	localparam logic [OP_W-1:0] OP_UVW    = 2'd3;

	// vector scaling
	localparam int DIF_W     = COORD_W + 1;
	localparam int MAG_W     = 2 * COORD_W + 1;
	localparam int SC_W      = 22;
	localparam int SH_W      = $clog2(MAG_W - SC_W + 1);
	localparam int SQ_W      = 2 * SC_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int SQ_SHIFT  = 18;
	localparam int SQ_X_W    = SUM_W + SQ_SHIFT;
	localparam int ROOT_W    = SQ_X_W / 2;
	localparam int SQRT_LAT  = ROOT_W;
	localparam int NUM_SHIFT = 9;
	localparam int NUM_W     = SC_W + LEN_W;

	// inversion
	localparam int CF_W   = 2 * COORD_W + 1;
	localparam int LO_W   = CF_W - COORD_W;
	localparam int DET_W  = 3 * COORD_W + 1;
	localparam int INV_NW = 2 * COORD_W + FRAC_BITS;
	localparam int SCL_NW = NUM_W + NUM_SHIFT;

	// divider widths, common to the scaling and inversion dividers
	localparam int DIV_NW  = (INV_NW > SCL_NW) ? INV_NW : SCL_NW;
	localparam int DIV_DW  = (DET_W - 1 > ROOT_W) ? DET_W - 1 : ROOT_W;
	localparam int QUO_W   = COORD_W + 1;
	localparam int DIV_LAT = QUO_W + 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VEC_W-1:0] origin_xyz;
		logic [VEC_W-1:0] first_xyz;
		logic [VEC_W-1:0] second_xyz;
		logic [VEC_W-1:0] third_xyz;
		logic [LEN_W-1:0] len_u;
		logic [LEN_W-1:0] len_v;
	} in_word_t;

	typedef struct packed {
		logic [VEC_W-1:0] row_zero;
		logic [VEC_W-1:0] row_one;
		logic [VEC_W-1:0] row_two;
		logic [VEC_W-1:0] origin_out;
		logic             singular;
	} out_word_t;

	function automatic coord_t comp(input logic [VEC_W-1:0] p, input int unsigned i);
		return coord_t'(p[i*COORD_W +: COORD_W]);
	endfunction

endpackage

>>> rtl/core/tsms_sqrt.sv
module tsms_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [tsms_pkg::SQ_X_W-1:0]  x,
	output logic [tsms_pkg::ROOT_W-1:0]  root
);
	import tsms_pkg::*;

	localparam int RW = ROOT_W + 3;

	logic [SQ_X_W-1:0] x_s   [ROOT_W];
	logic [RW-1:0]     rem_s [ROOT_W];
	logic [ROOT_W-1:0] rt_s  [ROOT_W];

	// one root bit per stage
	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic [SQ_X_W-1:0] x_in;
		logic [RW-1:0]     rem_in, rem_sh, trial;
		logic [ROOT_W-1:0] rt_in;

		if (i == 0) begin : g_first
			assign x_in   = x;
			assign rem_in = '0;
			assign rt_in  = '0;
		end else begin : g_next
			assign x_in   = x_s[i-1];
			assign rem_in = rem_s[i-1];
			assign rt_in  = rt_s[i-1];
		end

		assign rem_sh = {rem_in[RW-3:0], x_in[SQ_X_W-1 -: 2]};
		assign trial  = {1'b0, rt_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i] <= {x_in[SQ_X_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_s[i] <= rem_sh - trial;
					rt_s[i]  <= {rt_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= rem_sh;
					rt_s[i]  <= {rt_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = rt_s[ROOT_W-1];

endmodule

>>> rtl/core/tsms_div.sv
module tsms_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tsms_pkg::DIV_NW-1:0] num,
	input  logic [tsms_pkg::DIV_DW-1:0] den,
	input  logic                        neg,
	output tsms_pkg::coord_t            quo
);
	import tsms_pkg::*;

	localparam int CW = DIV_DW + QUO_W + 1;
	localparam logic [QUO_W:0] HALF = (QUO_W + 1)'(1) << (COORD_W - 1);

	logic [DIV_NW-1:0] n_s0;
	logic [DIV_DW-1:0] d_s0;
	logic              neg_s0, ovf_s0;

	logic [DIV_NW-1:0] r_s   [QUO_W];
	logic [QUO_W-1:0]  q_s   [QUO_W];
	logic [DIV_DW-1:0] d_s   [QUO_W];
	logic              neg_s [QUO_W];
	logic              ovf_s [QUO_W];

	logic [QUO_W:0]    qr;
	logic              up;
	coord_t            q_out_s;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s0   <= num;
			d_s0   <= den;
			neg_s0 <= neg;
			ovf_s0 <= CW'(num) >= (CW'(den) << QUO_W);
		end
	end

	// restoring division, one quotient bit per stage, high bit first
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int B = QUO_W - 1 - k;
		logic [DIV_NW-1:0] r_in;
		logic [QUO_W-1:0]  q_in;
		logic [DIV_DW-1:0] d_in;
		logic              neg_in, ovf_in, ge;
		logic [CW-1:0]     dsh;

		if (k == 0) begin : g_first
			assign r_in   = n_s0;
			assign q_in   = '0;
			assign d_in   = d_s0;
			assign neg_in = neg_s0;
			assign ovf_in = ovf_s0;
		end else begin : g_next
			assign r_in   = r_s[k-1];
			assign q_in   = q_s[k-1];
			assign d_in   = d_s[k-1];
			assign neg_in = neg_s[k-1];
			assign ovf_in = ovf_s[k-1];
		end

		assign dsh = CW'(d_in) << B;
		assign ge  = CW'(r_in) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]   <= ge ? r_in - dsh[DIV_NW-1:0] : r_in;
				q_s[k]   <= {q_in[QUO_W-2:0], ge};
				d_s[k]   <= d_in;
				neg_s[k] <= neg_in;
				ovf_s[k] <= ovf_in;
			end
		end
	end

	// round half up on magnitude, then sign and saturate
	always_comb begin
		up = (CW'(r_s[QUO_W-1]) << 1) >= CW'(d_s[QUO_W-1]);
		qr = (QUO_W + 1)'(q_s[QUO_W-1]) + (QUO_W + 1)'(up);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QUO_W-1]) begin
				if (ovf_s[QUO_W-1] || qr > HALF) q_out_s <= coord_t'(-HALF);
				else q_out_s <= coord_t'(-qr);
			end else begin
				if (ovf_s[QUO_W-1] || qr > HALF - 1'b1) q_out_s <= coord_t'(HALF - 1'b1);
				else q_out_s <= coord_t'(qr);
			end
		end
	end

	assign quo = q_out_s;

endmodule

>>> rtl/core/texture_space_matrix_setup.sv
// channel  | valid        | stall        | word
// input    | item_valid   | item_stall   | item   (op, origin, three vectors, lengths)
// output   | result_valid | result_stall | result (three rows, origin, singular)
// config   | cfg_we       | -            | cfg_wdata (det_epsilon)
// One word enters per cycle while item_stall is low; the latency is set by the square
// root and the two divider chains.
// arst_n clears all valid bits, output and skid included, and loads det_epsilon's reset value.
// A stalled result fills a one-word skid; the whole pipeline holds only while the skid is full.
module texture_space_matrix_setup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  tsms_pkg::in_word_t         item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output tsms_pkg::out_word_t        result,
	input  logic                       cfg_we,
	input  logic [tsms_pkg::EPS_W-1:0] cfg_wdata
);
	import tsms_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VEC_W-1:0] org;
		logic [VEC_W-1:0] fst;
		logic [VEC_W-1:0] snd;
		logic [VEC_W-1:0] thd;
	} frame_t;

	typedef struct packed {
		frame_t                 frm;
		logic [2:0]             zero;
		logic [8:0]             neg;
		logic [8:0][NUM_W-1:0]  num;
	} sq_side_t;

	typedef struct packed {
		frame_t     frm;
		logic [2:0] zero;
	} dv_side_t;

	typedef struct packed {
		logic [VEC_W-1:0]         org;
		logic                     sing;
		logic [8:0][COORD_W-1:0]  mat;
	} iv_side_t;

	localparam int unsigned NX [3] = '{1, 2, 0};
	localparam int unsigned NY [3] = '{2, 0, 1};
	localparam int unsigned CF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned CF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned CF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned CF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
	localparam int XD_W = 2 * COORD_W + 1;
	localparam int TSH  = 3 * FRAC_BITS - 30;
	localparam logic [XD_W-1:0] XHALF = XD_W'(1) << (COORD_W - 1);

	function automatic coord_t rnd_sat(input logic signed [XD_W-1:0] x);
		logic [XD_W-1:0] m;
		logic [XD_W-1:0] q;
		m = x[XD_W-1] ? XD_W'(-x) : XD_W'(x);
		q = (m + (XD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (x[XD_W-1]) return (q > XHALF) ? coord_t'(-XHALF) : coord_t'(-q);
		return (q > XHALF - 1'b1) ? coord_t'(XHALF - 1'b1) : coord_t'(q);
	endfunction

	logic             en;
	logic [EPS_W-1:0] eps_q;
	logic             out_vld_q, skid_vld_q;
	out_word_t        out_word_q, skid_word_q, p_word;
	logic             p_vld, take;
	logic [DET_W-1:0] thr;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;
	logic [SQRT_LAT-1:0] sq_vld_s;
	logic [DIV_LAT-1:0]  dv_vld_s, iv_vld_s;

	frame_t frm_s1, frm_s2, frm_s3, frm_s4, frm_s5, frm_s6, frm_s7;

	logic signed [DIF_W-1:0] d_s1 [3], e_s1 [3], d_s2 [3], e_s2 [3];
	coord_t                  t_s1 [3], t_s2 [3];
	logic [LEN_W-1:0]        lu_s1, lv_s1, lu_s2, lv_s2;
	logic signed [MAG_W-1:0] p_s2 [6];

	logic signed [MAG_W:0]   vx [9];
	logic [MAG_W-1:0]        mag_s3 [9], mag_s4 [9];
	logic [8:0]              neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [LEN_W-1:0]        len_s3 [3], len_s4 [3], len_s5 [3];
	logic [SH_W-1:0]         sh_c [3], sh_s4 [3];
	logic [SC_W-1:0]         a_s5 [9];
	logic [SQ_W-1:0]         sq_s6 [9];
	logic [NUM_W-1:0]        nm_s6 [9], nm_s7 [9];
	logic [SUM_W-1:0]        sum_s7 [3];

	sq_side_t          sq_in;
	sq_side_t          sq_dly_s [SQRT_LAT];
	dv_side_t          dv_dly_s [DIV_LAT];
	iv_side_t          iv_in;
	iv_side_t          iv_dly_s [DIV_LAT];
	logic [ROOT_W-1:0] root [3];
	coord_t            sc_q [9];
	coord_t            sc [9];
	coord_t            inv_q [9];

	coord_t                  u_s8 [3], v_s8 [3], w_s8 [3];
	logic                    crs_s8, crs_s9;
	logic [VEC_W-1:0]        org_s8, org_s9, org_s10, org_s11, org_s12, org_s13, org_s14, org_s15;
	coord_t                  u_s9 [3], v_s9 [3], w_s9 [3];
	logic signed [XD_W-2:0]  xp_s9 [6];
	coord_t                  a_s10 [9], a_s11 [9], a_s12 [9], a_s13 [9], a_s14 [9], a_s15 [9];
	logic signed [XD_W-2:0]  cp_s11 [18];
	logic signed [CF_W-1:0]  cof_s12 [9], cof_s13 [9], cof_s14 [9];
	logic signed [XD_W-2:0]  dh_s13 [3];
	logic signed [LO_W+COORD_W:0] dl_s13 [3];
	logic signed [DET_W-1:0] det_s14;
	logic [DET_W-2:0]        absdet;
	logic                    sing_s15;
	logic [DIV_NW-1:0]       dn_s15 [9];
	logic [DIV_DW-1:0]       den_s15;
	logic [8:0]              ng_s15;

	assign en         = !skid_vld_q;
	assign item_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	if (TSH >= 0) begin : g_thr_up
		assign thr = DET_W'(eps_q) << TSH;
	end else begin : g_thr_down
		assign thr = (DET_W'(eps_q) + ((DET_W'(1) << (-TSH)) - 1'b1)) >> (-TSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
			{vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15} <= '0;
			sq_vld_s <= '0;
			dv_vld_s <= '0;
			iv_vld_s <= '0;
		end else if (en) begin
			vld_s1   <= item_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_s7   <= vld_s6;
			sq_vld_s <= {sq_vld_s[SQRT_LAT-2:0], vld_s7};
			dv_vld_s <= {dv_vld_s[DIV_LAT-2:0], sq_vld_s[SQRT_LAT-1]};
			vld_s8   <= dv_vld_s[DIV_LAT-1];
			vld_s9   <= vld_s8;
			vld_s10  <= vld_s9;
			vld_s11  <= vld_s10;
			vld_s12  <= vld_s11;
			vld_s13  <= vld_s12;
			vld_s14  <= vld_s13;
			vld_s15  <= vld_s14;
			iv_vld_s <= {iv_vld_s[DIV_LAT-2:0], vld_s15};
		end
	end

	// scaling inputs: A = first - origin, B = cross or second - origin, C = third
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i]     = (MAG_W + 1)'(d_s2[i]);
			vx[3 + i] = (frm_s2.op == OP_NORMAL) ?
				(MAG_W + 1)'(p_s2[2*i]) - (MAG_W + 1)'(p_s2[2*i+1]) :
				(MAG_W + 1)'(e_s2[i]);
			vx[6 + i] = (MAG_W + 1)'(t_s2[i]);
		end
	end

	// normalizing shift from the leading one of the vector
	always_comb begin
		logic [MAG_W-1:0] orv;
		int msb;
		for (int j = 0; j < 3; j++) begin
			orv = mag_s3[3*j] | mag_s3[3*j+1] | mag_s3[3*j+2];
			msb = 0;
			for (int b = 0; b < MAG_W; b++) begin
				if (orv[b]) msb = b;
			end
			sh_c[j] = (msb >= SC_W) ? SH_W'(msb - SC_W + 1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			frm_s1 <= '{op: item.op, org: item.origin_xyz, fst: item.first_xyz,
				snd: item.second_xyz, thd: item.third_xyz};
			lu_s1 <= item.len_u;
			lv_s1 <= item.len_v;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIF_W'(comp(item.first_xyz, i)) - DIF_W'(comp(item.origin_xyz, i));
				e_s1[i] <= DIF_W'(comp(item.second_xyz, i)) - DIF_W'(comp(item.origin_xyz, i));
				t_s1[i] <= comp(item.third_xyz, i);
			end
			// s2
			frm_s2 <= frm_s1;
			lu_s2  <= lu_s1;
			lv_s2  <= lv_s1;
			for (int i = 0; i < 3; i++) begin
				d_s2[i]     <= d_s1[i];
				e_s2[i]     <= e_s1[i];
				t_s2[i]     <= t_s1[i];
				p_s2[2*i]   <= MAG_W'(d_s1[NX[i]]) * MAG_W'(t_s1[NY[i]]);
				p_s2[2*i+1] <= MAG_W'(d_s1[NY[i]]) * MAG_W'(t_s1[NX[i]]);
			end
			// s3
			frm_s3    <= frm_s2;
			len_s3[0] <= lu_s2;
			len_s3[1] <= (frm_s2.op == OP_NORMAL) ? lu_s2 : lv_s2;
			len_s3[2] <= lu_s2;
			for (int k = 0; k < 9; k++) begin
				mag_s3[k] <= vx[k][MAG_W] ? MAG_W'(-vx[k]) : MAG_W'(vx[k]);
				neg_s3[k] <= vx[k][MAG_W];
			end
			// s4
			frm_s4 <= frm_s3;
			neg_s4 <= neg_s3;
			for (int j = 0; j < 3; j++) begin
				len_s4[j] <= len_s3[j];
				sh_s4[j]  <= sh_c[j];
			end
			for (int k = 0; k < 9; k++) mag_s4[k] <= mag_s3[k];
			// s5
			frm_s5 <= frm_s4;
			neg_s5 <= neg_s4;
			for (int j = 0; j < 3; j++) len_s5[j] <= len_s4[j];
			for (int k = 0; k < 9; k++) a_s5[k] <= SC_W'(mag_s4[k] >> sh_s4[k/3]);
			// s6
			frm_s6 <= frm_s5;
			neg_s6 <= neg_s5;
			for (int k = 0; k < 9; k++) begin
				sq_s6[k] <= SQ_W'(a_s5[k]) * SQ_W'(a_s5[k]);
				nm_s6[k] <= NUM_W'(a_s5[k]) * NUM_W'(len_s5[k/3]);
			end
			// s7
			frm_s7 <= frm_s6;
			neg_s7 <= neg_s6;
			for (int k = 0; k < 9; k++) nm_s7[k] <= nm_s6[k];
			for (int j = 0; j < 3; j++) begin
				sum_s7[j] <= SUM_W'(sq_s6[3*j]) + SUM_W'(sq_s6[3*j+1]) + SUM_W'(sq_s6[3*j+2]);
			end
			// side data across the root and divider chains
			sq_dly_s[0] <= sq_in;
			for (int k = 1; k < SQRT_LAT; k++) sq_dly_s[k] <= sq_dly_s[k-1];
			dv_dly_s[0] <= '{frm: sq_dly_s[SQRT_LAT-1].frm, zero: sq_dly_s[SQRT_LAT-1].zero};
			for (int k = 1; k < DIV_LAT; k++) dv_dly_s[k] <= dv_dly_s[k-1];
			// s8: basis select
			org_s8 <= dv_dly_s[DIV_LAT-1].frm.org;
			crs_s8 <= (dv_dly_s[DIV_LAT-1].frm.op == OP_ENDS) ||
				(dv_dly_s[DIV_LAT-1].frm.op == OP_UV);
			for (int i = 0; i < 3; i++) begin
				case (dv_dly_s[DIV_LAT-1].frm.op)
					OP_NORMAL, OP_ENDS: begin
						u_s8[i] <= sc[i];
						v_s8[i] <= sc[3+i];
						w_s8[i] <= sc[6+i];
					end
					default: begin
						u_s8[i] <= comp(dv_dly_s[DIV_LAT-1].frm.fst, i);
						v_s8[i] <= comp(dv_dly_s[DIV_LAT-1].frm.snd, i);
						w_s8[i] <= comp(dv_dly_s[DIV_LAT-1].frm.thd, i);
					end
				endcase
			end
			// s9: cross products
			org_s9 <= org_s8;
			crs_s9 <= crs_s8;
			for (int i = 0; i < 3; i++) begin
				u_s9[i]      <= u_s8[i];
				v_s9[i]      <= v_s8[i];
				w_s9[i]      <= w_s8[i];
				xp_s9[2*i]   <= (XD_W - 1)'(u_s8[NX[i]]) * (XD_W - 1)'(v_s8[NY[i]]);
				xp_s9[2*i+1] <= (XD_W - 1)'(u_s8[NY[i]]) * (XD_W - 1)'(v_s8[NX[i]]);
			end
			// s10: matrix with columns u, v and w, or u x v in place of w for OP_ENDS and OP_UV
			org_s10 <= org_s9;
			for (int i = 0; i < 3; i++) begin
				a_s10[3*i]   <= u_s9[i];
				a_s10[3*i+1] <= v_s9[i];
				a_s10[3*i+2] <= crs_s9 ?
					rnd_sat(XD_W'(xp_s9[2*i]) - XD_W'(xp_s9[2*i+1])) : w_s9[i];
			end
			// s11: cofactor products
			org_s11 <= org_s10;
			for (int k = 0; k < 9; k++) begin
				a_s11[k]      <= a_s10[k];
				cp_s11[2*k]   <= (XD_W - 1)'(a_s10[CF_A[k]]) * (XD_W - 1)'(a_s10[CF_B[k]]);
				cp_s11[2*k+1] <= (XD_W - 1)'(a_s10[CF_C[k]]) * (XD_W - 1)'(a_s10[CF_D[k]]);
			end
			// s12: cofactors
			org_s12 <= org_s11;
			for (int k = 0; k < 9; k++) begin
				a_s12[k]   <= a_s11[k];
				cof_s12[k] <= CF_W'(cp_s11[2*k]) - CF_W'(cp_s11[2*k+1]);
			end
			// s13: determinant partial products, cofactor split in two halves
			org_s13 <= org_s12;
			for (int k = 0; k < 9; k++) begin
				a_s13[k]   <= a_s12[k];
				cof_s13[k] <= cof_s12[k];
			end
			for (int j = 0; j < 3; j++) begin
				dh_s13[j] <= (XD_W - 1)'(a_s12[j]) *
					(XD_W - 1)'($signed(cof_s12[3*j][CF_W-1:LO_W]));
				dl_s13[j] <= (LO_W + COORD_W + 1)'(a_s12[j]) *
					(LO_W + COORD_W + 1)'($signed({1'b0, cof_s12[3*j][LO_W-1:0]}));
			end
			// s14: determinant
			org_s14 <= org_s13;
			for (int k = 0; k < 9; k++) begin
				a_s14[k]   <= a_s13[k];
				cof_s14[k] <= cof_s13[k];
			end
			det_s14 <= (DET_W'(dh_s13[0]) << LO_W) + DET_W'(dl_s13[0]) +
				(DET_W'(dh_s13[1]) << LO_W) + DET_W'(dl_s13[1]) +
				(DET_W'(dh_s13[2]) << LO_W) + DET_W'(dl_s13[2]);
			// s15: singular test and divider operands
			org_s15  <= org_s14;
			sing_s15 <= (det_s14 == '0) || (DET_W'(absdet) < thr);
			den_s15  <= DIV_DW'(absdet);
			for (int k = 0; k < 9; k++) begin
				a_s15[k]  <= a_s14[k];
				dn_s15[k] <= DIV_NW'(cof_s14[k][CF_W-1] ? CF_W'(-cof_s14[k]) : CF_W'(cof_s14[k]))
					<< FRAC_BITS;
				ng_s15[k] <= cof_s14[k][CF_W-1] ^ det_s14[DET_W-1];
			end
			iv_dly_s[0] <= iv_in;
			for (int k = 1; k < DIV_LAT; k++) iv_dly_s[k] <= iv_dly_s[k-1];
		end
	end

	assign absdet = det_s14[DET_W-1] ? (DET_W - 1)'(-det_s14) : (DET_W - 1)'(det_s14);

	always_comb begin
		sq_in.frm  = frm_s7;
		sq_in.neg  = neg_s7;
		for (int j = 0; j < 3; j++) sq_in.zero[j] = (sum_s7[j] == '0);
		for (int k = 0; k < 9; k++) sq_in.num[k] = nm_s7[k];
		iv_in.org  = org_s15;
		iv_in.sing = sing_s15;
		for (int k = 0; k < 9; k++) iv_in.mat[k] = a_s15[k];
	end

	for (genvar j = 0; j < 3; j++) begin : g_root
		tsms_sqrt u_sqrt (
			.clk  (clk),
			.en   (en),
			.x    ({sum_s7[j], {SQ_SHIFT{1'b0}}}),
			.root (root[j])
		);
	end

	for (genvar k = 0; k < 9; k++) begin : g_scale
		tsms_div u_div (
			.clk (clk),
			.en  (en),
			.num (DIV_NW'(sq_dly_s[SQRT_LAT-1].num[k]) << NUM_SHIFT),
			.den (DIV_DW'(root[k/3])),
			.neg (sq_dly_s[SQRT_LAT-1].neg[k]),
			.quo (sc_q[k])
		);
		assign sc[k] = dv_dly_s[DIV_LAT-1].zero[k/3] ? '0 : sc_q[k];
	end

	for (genvar k = 0; k < 9; k++) begin : g_inv
		tsms_div u_div (
			.clk (clk),
			.en  (en),
			.num (dn_s15[k]),
			.den (den_s15),
			.neg (ng_s15[k]),
			.quo (inv_q[k])
		);
	end

	always_comb begin
		iv_side_t   sd;
		logic [8:0][COORD_W-1:0] m;
		sd = iv_dly_s[DIV_LAT-1];
		for (int k = 0; k < 9; k++) m[k] = sd.sing ? sd.mat[k] : inv_q[k];
		p_vld             = iv_vld_s[DIV_LAT-1];
		p_word.row_zero   = {m[2], m[1], m[0]};
		p_word.row_one    = {m[5], m[4], m[3]};
		p_word.row_two    = {m[8], m[7], m[6]};
		p_word.origin_out = sd.org;
		p_word.singular   = sd.sing;
	end

	// output register with one-word skid
	assign take = out_vld_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			out_vld_q <= p_vld;
		end else if (p_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) out_word_q <= skid_word_q;
		end else if (!out_vld_q || take) begin
			out_word_q <= p_word;
		end else begin
			skid_word_q <= p_word;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_word_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a word while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && result_stall && iv_vld_s[DIV_LAT-1]))
		else $error("skid filled without a stalled result and a finished word");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && $past(skid_vld_q)) |-> $stable(iv_vld_s))
		else $error("pipeline moved while skid was full");

endmodule
